>>> hdl/plc_pkg.sv
// Shared types, codes and register reset values for the parallax layer compositor.
package plc_pkg;

  localparam int NUM_STEPS = 5;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_SCROLL = 2'd1,
    MODE_READ   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    REG_STEP_ONE    = 3'd0,
    REG_STEP_TWO    = 3'd1,
    REG_STEP_THREE  = 3'd2,
    REG_STEP_FOUR   = 3'd3,
    REG_GROUND_STEP = 3'd4,
    REG_KEY         = 3'd5
  } reg_idx_e;

  localparam logic [2:0] LAYER_BASE      = 3'd0;
  localparam logic [2:0] LAYER_OVL_FIRST = 3'd1;
  localparam logic [2:0] LAYER_GROUND    = 3'd5;

  // Step reset values, step_one in the low byte.
  localparam logic [NUM_STEPS-1:0][7:0] STEP_RST = {8'd1, 8'd4, 8'd3, 8'd2, 8'd1};

  typedef struct packed {
    logic [NUM_STEPS-1:0][7:0] step;
    logic [31:0]               key;
  } cfg_t;

endpackage

>>> hdl/parallax_layer_compositor.sv
// Top level of the parallax layer compositor: address stage, layer memories, compose stage.
//
//   channel  direction  handshake                 word
//   in       input      in_valid_i / in_stall_o   mode, layer_sel, col, row, pixel_in, direction
//   out      output     out_valid_o / out_stall_i pixel_out, col_out, row_out
//   cfg      input      APB psel/penable/pwrite   step_one .. ground_step, transparent_key
//
// One input word is taken every cycle while in_stall_o is low. The accepting edge of a read
// word latches the reads of all six layer memories into the memory stage; from there the
// composed pixel is loaded into the output register once that register is empty or its
// word is taken. Loads write their memory at the accepting edge, and a scroll moves the
// offsets in time for the next word. Reset clears the offsets, the configuration registers
// and the valid flags only; the stores need no clearing pass. in_stall_o rises only while a
// read waits in the memory stage behind a stalled output register.
module parallax_layer_compositor import plc_pkg::*; #(
  parameter int WIDTH       = 256,
  parameter int HEIGHT      = 128,
  parameter int GROUND_ROWS = 16,
  parameter int PIXEL_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [2:0]  layer_sel_i,
  input  logic [7:0]  col_i,
  input  logic [6:0]  row_i,
  input  logic [31:0] pixel_in_i,
  input  logic [1:0]  direction_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pixel_out_o,
  output logic [7:0]  col_out_o,
  output logic [6:0]  row_out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int OFF_W      = $clog2(WIDTH);
  localparam int BASE_DEPTH = WIDTH * HEIGHT;
  localparam int BA_W       = $clog2(BASE_DEPTH);
  localparam int GND_DEPTH  = WIDTH * GROUND_ROWS;
  localparam int GA_W       = $clog2(GND_DEPTH);
  localparam int GROUND_EFF = (GROUND_ROWS < HEIGHT) ? GROUND_ROWS : HEIGHT;
  localparam int GROUND_TOP = HEIGHT - GROUND_EFF;
  localparam int NUM_OVL    = 4;

  cfg_t                            cfg;
  logic [NUM_STEPS-1:0][OFF_W-1:0] off;

  logic       in_acc, advance;
  logic       is_load, is_scroll, is_read;
  mode_e      mode;
  logic       col_ok, row_ok, gnd_row_ok, gnd_hit;
  logic [PIXEL_BITS-1:0] pix_in;
  logic [OFF_W-1:0]      col_n;
  logic [31:0]           lin_wr, gnd_rd_lin;
  logic [NUM_OVL-1:0][31:0] ovl_rd_lin;

  logic                  we_base, we_gnd;
  logic [NUM_OVL-1:0]    we_ovl;
  logic [PIXEL_BITS-1:0] base_rd, gnd_rd;
  logic [NUM_OVL-1:0][PIXEL_BITS-1:0] ovl_rd;

  logic       s1_valid_q, s1_valid_d;
  logic       s1_ok_q, s1_gnd_q;
  logic [7:0] s1_col_q;
  logic [6:0] s1_row_q;

  logic                  out_valid_q, out_valid_d;
  logic [31:0]           out_pixel_q, out_pixel_d;
  logic [7:0]            out_col_q;
  logic [6:0]            out_row_q;
  logic [PIXEL_BITS-1:0] mix;

  function automatic logic [OFF_W-1:0] wrap_col(input logic [OFF_W-1:0] c,
                                                input logic [OFF_W-1:0] o);
    logic [OFF_W:0] s;
    s = {1'b0, c} + {1'b0, o};
    if (s >= (OFF_W+1)'(WIDTH)) begin
      s = s - (OFF_W+1)'(WIDTH);
    end
    return s[OFF_W-1:0];
  endfunction

  plc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  assign pready = 1'b1;

  // Input decode.
  assign in_acc    = in_valid_i && !in_stall_o;
  assign mode      = mode_e'(mode_i);
  assign is_load   = in_acc && (mode == MODE_LOAD);
  assign is_scroll = in_acc && (mode == MODE_SCROLL);
  assign is_read   = in_acc && (mode == MODE_READ);

  assign col_ok     = 32'(col_i) < 32'(WIDTH);
  assign row_ok     = 32'(row_i) < 32'(HEIGHT);
  assign gnd_row_ok = 32'(row_i) < 32'(GROUND_ROWS);
  assign gnd_hit    = 32'(row_i) >= 32'(GROUND_TOP);
  assign pix_in     = pixel_in_i[PIXEL_BITS-1:0];
  assign col_n      = OFF_W'(col_i);

  plc_scroll #(
    .WIDTH (WIDTH),
    .OFF_W (OFF_W)
  ) u_scroll (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .scroll_i (is_scroll),
    .dir_i    (dir_e'(direction_i)),
    .cfg_i    (cfg),
    .off_o    (off)
  );

  // Linear addresses; out-of-range requests never write and read as zero downstream.
  always_comb begin
    lin_wr     = 32'(row_i) * 32'(WIDTH) + 32'(col_i);
    gnd_rd_lin = (32'(row_i) - 32'(GROUND_TOP)) * 32'(WIDTH)
               + 32'(wrap_col(col_n, off[NUM_STEPS-1]));
    for (int k = 0; k < NUM_OVL; k++) begin
      ovl_rd_lin[k] = 32'(row_i) * 32'(WIDTH) + 32'(wrap_col(col_n, off[k]));
    end
  end

  assign we_base = is_load && col_ok && row_ok && (layer_sel_i == LAYER_BASE);
  assign we_gnd  = is_load && col_ok && gnd_row_ok && (layer_sel_i == LAYER_GROUND);

  plc_ram #(
    .DEPTH (BASE_DEPTH),
    .AW    (BA_W),
    .DW    (PIXEL_BITS)
  ) u_base_ram (
    .clk_i   (clk_i),
    .we_i    (we_base),
    .waddr_i (lin_wr[BA_W-1:0]),
    .wdata_i (pix_in),
    .re_i    (is_read),
    .raddr_i (lin_wr[BA_W-1:0]),
    .rdata_o (base_rd)
  );

  for (genvar k = 0; k < NUM_OVL; k++) begin : g_ovl
    assign we_ovl[k] = is_load && col_ok && row_ok
                    && (layer_sel_i == 3'(LAYER_OVL_FIRST + 3'(k)));

    plc_ram #(
      .DEPTH (BASE_DEPTH),
      .AW    (BA_W),
      .DW    (PIXEL_BITS)
    ) u_ovl_ram (
      .clk_i   (clk_i),
      .we_i    (we_ovl[k]),
      .waddr_i (lin_wr[BA_W-1:0]),
      .wdata_i (pix_in),
      .re_i    (is_read),
      .raddr_i (ovl_rd_lin[k][BA_W-1:0]),
      .rdata_o (ovl_rd[k])
    );
  end

  plc_ram #(
    .DEPTH (GND_DEPTH),
    .AW    (GA_W),
    .DW    (PIXEL_BITS)
  ) u_gnd_ram (
    .clk_i   (clk_i),
    .we_i    (we_gnd),
    .waddr_i (lin_wr[GA_W-1:0]),
    .wdata_i (pix_in),
    .re_i    (is_read),
    .raddr_i (gnd_rd_lin[GA_W-1:0]),
    .rdata_o (gnd_rd)
  );

  // Memory stage: holds the read word while the output register is stalled.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign s1_valid_d = is_read || (s1_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_read) begin
      s1_col_q <= col_i;
      s1_row_q <= row_i;
      s1_ok_q  <= col_ok && row_ok;
      s1_gnd_q <= gnd_hit;
    end
  end

  // Compose: ground rows first, then the topmost visible overlay, else base; out of frame gives 0.
  always_comb begin
    mix = base_rd;
    for (int k = 0; k < NUM_OVL; k++) begin
      if (ovl_rd[k] != cfg.key[PIXEL_BITS-1:0]) begin
        mix = ovl_rd[k];
      end
    end
    if (s1_gnd_q) begin
      mix = gnd_rd;
    end
    if (!s1_ok_q) begin
      mix = '0;
    end
  end

  assign out_pixel_d = 32'(mix);
  assign out_valid_d = advance ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_pixel_q <= out_pixel_d;
      out_col_q   <= s1_col_q;
      out_row_q   <= s1_row_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_pixel_q;
  assign col_out_o   = out_col_q;
  assign row_out_o   = out_row_q;

endmodule

>>> hdl/plc_ram.sv
// Simple dual-port pixel memory with a registered read.
module plc_ram #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15,
  parameter int DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/plc_regs.sv
// APB configuration registers: scroll steps and transparent key.
module plc_regs import plc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output cfg_t        cfg_o
);

  logic [NUM_STEPS-1:0][7:0] step_q, step_d;
  logic [31:0]               key_q, key_d;
  reg_idx_e                  idx;
  logic                      wr;

  assign idx = reg_idx_e'(paddr[4:2]);
  assign wr  = psel && penable && pwrite;

  always_comb begin
    step_d = step_q;
    key_d  = key_q;
    if (wr) begin
      if (idx inside {[REG_STEP_ONE:REG_GROUND_STEP]}) begin
        step_d[idx] = pwdata[7:0];
      end else if (idx == REG_KEY) begin
        key_d = pwdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RST;
      key_q  <= '0;
    end else begin
      step_q <= step_d;
      key_q  <= key_d;
    end
  end

  always_comb begin
    case (idx)
      REG_STEP_ONE, REG_STEP_TWO, REG_STEP_THREE, REG_STEP_FOUR,
      REG_GROUND_STEP: prdata = {24'd0, step_q[idx]};
      REG_KEY:         prdata = key_q;
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.step = step_q;
  assign cfg_o.key  = key_q;

endmodule

>>> hdl/plc_scroll.sv
// Scroll offsets of the four overlays and the ground strip, kept modulo the width.
module plc_scroll import plc_pkg::*; #(
  parameter int WIDTH = 256,
  parameter int OFF_W = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            scroll_i,
  input  dir_e                            dir_i,
  input  cfg_t                            cfg_i,
  output logic [NUM_STEPS-1:0][OFF_W-1:0] off_o
);

  logic [NUM_STEPS-1:0][OFF_W-1:0] off_q, off_d;

  // An 8-bit step never exceeds 15 widths, so four conditional subtracts reduce it.
  function automatic logic [OFF_W-1:0] step_mod(input logic [7:0] s);
    logic [15:0] v;
    v = 16'(s);
    for (int i = 3; i >= 0; i--) begin
      if (v >= 16'(WIDTH << i)) begin
        v = v - 16'(WIDTH << i);
      end
    end
    return v[OFF_W-1:0];
  endfunction

  always_comb begin
    logic [OFF_W-1:0] s;
    logic [OFF_W:0]   sum;
    off_d = off_q;
    for (int k = 0; k < NUM_STEPS; k++) begin
      s   = step_mod(cfg_i.step[k]);
      sum = {1'b0, off_q[k]};
      case (dir_i)
        DIR_LEFT: begin
          sum = {1'b0, off_q[k]} + {1'b0, s};
          if (sum >= (OFF_W+1)'(WIDTH)) begin
            sum = sum - (OFF_W+1)'(WIDTH);
          end
        end
        DIR_RIGHT: begin
          if (off_q[k] >= s) begin
            sum = {1'b0, off_q[k]} - {1'b0, s};
          end else begin
            sum = {1'b0, off_q[k]} + (OFF_W+1)'(WIDTH) - {1'b0, s};
          end
        end
        default: sum = {1'b0, off_q[k]};
      endcase
      if (scroll_i) begin
        off_d[k] = sum[OFF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
    end else begin
      off_q <= off_d;
    end
  end

  assign off_o = off_q;

endmodule

>>> hdl/plc_checker.sv
// Port-level assertions for the parallax layer compositor, with their bind.
module plc_port_checks import plc_pkg::*; #(
  parameter int WIDTH  = 256,
  parameter int HEIGHT = 128
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  mode_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] pixel_out_o,
  input logic [7:0]  col_out_o,
  input logic [6:0]  row_out_o,
  input logic        pready
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_out_o)
      && $stable(col_out_o) && $stable(row_out_o))
    else $error("result word changed while stalled");

  // An accepted read is always followed by a valid result word.
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i == MODE_READ) |-> ##2 out_valid_o)
    else $error("read word produced no result");

  // The input side only stalls behind a stalled, full output register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // Reads outside the frame return a zero pixel.
  a_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((32'(col_out_o) >= 32'(WIDTH)) || (32'(row_out_o) >= 32'(HEIGHT)))
      |-> pixel_out_o == 32'd0)
    else $error("out-of-frame read returned a nonzero pixel");

  a_pready: assert property (@(posedge clk_i) pready)
    else $error("pready dropped");

endmodule

bind parallax_layer_compositor plc_port_checks #(
  .WIDTH  (WIDTH),
  .HEIGHT (HEIGHT)
) u_plc_port_checks (.*);
